>>> rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared constants and types for the text console character writer
// Screen geometry, character and cell codes, and the cursor bundle passed
// from the cursor unit to the controller.
// ----------------------------------------------------------------------------
package tcw_pkg;

	// Screen geometry and the widths of the index, column and row fields.
	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int NCELLS  = COLUMNS * ROWS;

	localparam int IDX_W = 11;
	localparam int COL_W = 7;
	localparam int ROW_W = 5;

	// Character and cell codes.
	localparam logic [7:0]  NEWLINE_CODE = 8'h0A;
	localparam logic [7:0]  SPACE_CODE   = 8'h20;
	localparam logic [15:0] ATTR_MASK    = 16'hFF00;
	localparam logic [15:0] BLANK_CELL   = 16'h0720;

	// Cursor view: the cell under the cursor and the cursor after one request.
	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [COL_W-1:0] col_nxt;
		logic [ROW_W-1:0] row_nxt;
		logic             wrap;
	} cursor_t;

endpackage

>>> rtl/tcw_screen_ram.sv
// ----------------------------------------------------------------------------
// tcw_screen_ram: screen cell memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tcw_screen_ram (
	input  logic                      clk,
	input  logic                      we,
	input  logic [tcw_pkg::IDX_W-1:0] waddr,
	input  logic [15:0]               wdata,
	input  logic                      re,
	input  logic [tcw_pkg::IDX_W-1:0] raddr,
	output logic [15:0]               rdata
);

	logic [15:0] mem [tcw_pkg::NCELLS];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/tcw_cursor.sv
// ----------------------------------------------------------------------------
// tcw_cursor: cursor position register and next-position logic
// Holds column and row, gives the linear cell index under the cursor and the
// position after the pending character, including wrap and screen overflow.
// ----------------------------------------------------------------------------
module tcw_cursor (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic             is_newline,
	output tcw_pkg::cursor_t cur
);

	logic [tcw_pkg::COL_W-1:0] col_q;
	logic [tcw_pkg::ROW_W-1:0] row_q;
	logic [tcw_pkg::COL_W:0]   col_inc;
	logic [tcw_pkg::ROW_W:0]   row_inc;
	logic [tcw_pkg::COL_W:0]   col_n;
	logic [tcw_pkg::ROW_W:0]   row_n;

	// Linear index of the cell under the cursor, and the next position: newline
	// or row end moves to the next row; past the last row the cursor goes home.
	always_comb begin
		cur.idx = tcw_pkg::IDX_W'(row_q) * tcw_pkg::IDX_W'(tcw_pkg::COLUMNS)
		        + tcw_pkg::IDX_W'(col_q);
		col_inc = {1'b0, col_q} + 1'b1;
		row_inc = {1'b0, row_q} + 1'b1;
		if (is_newline || (col_inc >= (tcw_pkg::COL_W+1)'(tcw_pkg::COLUMNS))) begin
			col_n = '0;
			row_n = row_inc;
		end else begin
			col_n = col_inc;
			row_n = {1'b0, row_q};
		end
		cur.wrap = (row_n >= (tcw_pkg::ROW_W+1)'(tcw_pkg::ROWS));
		if (cur.wrap) begin
			col_n = '0;
			row_n = '0;
		end
		cur.col_nxt = col_n[tcw_pkg::COL_W-1:0];
		cur.row_nxt = row_n[tcw_pkg::ROW_W-1:0];
	end

	// Position register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			col_q <= cur.col_nxt;
			row_q <= cur.row_nxt;
		end
	end

endmodule

>>> rtl/text_console_char_writer.sv
// ----------------------------------------------------------------------------
// text_console_char_writer: text console character writer
// Writes character codes into a screen cell memory at a moving cursor,
// keeping each cell's attribute, and clears all characters on overflow.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+--------------------------
//   char     | in        | char_valid / char_stall | char_code
//   res      | out       | res_valid / res_stall   | wrote_cell, cell_index,
//            |           |                         | cell_word, cursor_col,
//            |           |                         | cursor_row, screen_cleared
//
// Each request reads the cell from the screen memory, then writes it back
// and loads the result register.
// After reset a fill pass writes blank cells to all 2000 cells before the
// first request is taken.
// An overflow starts a clearing pass through the memory read and write
// ports after its result is loaded; no request is taken meanwhile.
// A stalled result holds the controller in its write step; a request may be
// taken while a finished result still waits.
// ----------------------------------------------------------------------------
module text_console_char_writer (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      char_valid,
	output logic                      char_stall,
	input  logic [7:0]                char_code,
	output logic                      res_valid,
	input  logic                      res_stall,
	output logic                      wrote_cell,
	output logic [tcw_pkg::IDX_W-1:0] cell_index,
	output logic [15:0]               cell_word,
	output logic [tcw_pkg::COL_W-1:0] cursor_col,
	output logic [tcw_pkg::ROW_W-1:0] cursor_row,
	output logic                      screen_cleared
);

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_WRITE,
		S_CLEAR,
		S_CLEAR_END
	} state_t;

	localparam logic [tcw_pkg::IDX_W-1:0] LAST_CELL = tcw_pkg::IDX_W'(tcw_pkg::NCELLS - 1);

	state_t                    state_q;
	logic [tcw_pkg::IDX_W-1:0] cnt_q;
	logic [7:0]                code_q;

	tcw_pkg::cursor_t          cur;
	logic                      is_newline;
	logic                      out_free;
	logic                      load_res;

	logic                      mem_we;
	logic [tcw_pkg::IDX_W-1:0] mem_waddr;
	logic [15:0]               mem_wdata;
	logic                      mem_re;
	logic [tcw_pkg::IDX_W-1:0] mem_raddr;
	logic [15:0]               mem_rdata;
	logic [15:0]               new_word;

	// Handshake and step control.
	assign char_stall = (state_q != S_IDLE);
	assign out_free   = !res_valid || !res_stall;
	assign is_newline = (code_q == tcw_pkg::NEWLINE_CODE);
	assign load_res   = (state_q == S_WRITE) && out_free;
	assign new_word   = (mem_rdata & tcw_pkg::ATTR_MASK) | {8'h00, code_q};

	tcw_cursor u_cursor (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (load_res),
		.is_newline (is_newline),
		.cur        (cur)
	);

	// Memory read: the cell under the cursor on a request, the sweep address
	// during a clearing pass.
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = cur.idx;
		case (state_q)
			S_IDLE: begin
				mem_re = char_valid;
			end
			S_CLEAR: begin
				mem_re    = 1'b1;
				mem_raddr = cnt_q;
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	// Memory write: blank fill, character write back, or clearing write one
	// cell behind the read sweep.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cnt_q;
		mem_wdata = (mem_rdata & tcw_pkg::ATTR_MASK) | {8'h00, tcw_pkg::SPACE_CODE};
		case (state_q)
			S_INIT: begin
				mem_we    = 1'b1;
				mem_wdata = tcw_pkg::BLANK_CELL;
			end
			S_WRITE: begin
				mem_we    = load_res && !is_newline;
				mem_waddr = cur.idx;
				mem_wdata = new_word;
			end
			S_CLEAR: begin
				mem_we    = (cnt_q != '0);
				mem_waddr = cnt_q - 1'b1;
			end
			S_CLEAR_END: begin
				mem_we    = 1'b1;
				mem_waddr = LAST_CELL;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	tcw_screen_ram u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Controller state, sweep counter and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_INIT;
			cnt_q     <= '0;
			res_valid <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				res_valid <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					if (cnt_q == LAST_CELL) begin
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (char_valid) begin
						code_q  <= char_code;
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					if (out_free) begin
						res_valid      <= 1'b1;
						wrote_cell     <= !is_newline;
						cell_index     <= is_newline ? '0 : cur.idx;
						cell_word      <= is_newline ? '0 : new_word;
						cursor_col     <= cur.col_nxt;
						cursor_row     <= cur.row_nxt;
						screen_cleared <= cur.wrap;
						cnt_q          <= '0;
						state_q        <= cur.wrap ? S_CLEAR : S_IDLE;
					end
				end
				S_CLEAR: begin
					if (cnt_q == LAST_CELL) begin
						state_q <= S_CLEAR_END;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_CLEAR_END: begin
					cnt_q   <= '0;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The screen is never written while the controller waits for a request.
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mem_we)
		else $error("screen written while idle");

	// An accepted request always leads to the write step.
	a_accept_write: assert property (@(posedge clk) disable iff (!arst_n)
		(char_valid && !char_stall) |=> (state_q == S_WRITE))
		else $error("accepted request did not reach write step");

	// A clearing result reports the cursor at home.
	a_clear_home: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && screen_cleared) |-> (cursor_col == '0 && cursor_row == '0))
		else $error("clear without cursor at home");

	// A reported cursor always lies on the screen.
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (cursor_col < tcw_pkg::COL_W'(tcw_pkg::COLUMNS)
		            && cursor_row < tcw_pkg::ROW_W'(tcw_pkg::ROWS)))
		else $error("cursor out of range");

	// A newline result carries no cell.
	a_newline_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !wrote_cell) |-> (cell_word == '0 && cell_index == '0))
		else $error("newline result carries cell data");

endmodule
